// File: hw/rtl/dnle_pkg.sv
// dnle_pkg: shared constants for the dns name label encoder
// no dependencies; imported by the encoder top level and its assertions
`timescale 1ns / 1ps

package dnle_pkg;

  localparam int BYTE_W        = 8;
  localparam int USER_W        = 2;
  localparam int LABEL_MAX_DEF = 62;

  localparam logic [BYTE_W-1:0] DOT_CHAR  = 8'h2E;
  localparam logic [BYTE_W-1:0] NULL_CHAR = 8'h00;

  // m_tuser bit positions
  localparam int USER_DONE = 0;
  localparam int USER_TL   = 1;

endpackage

// File: hw/rtl/dnle_ram.sv
// dnle_ram: generic single write port, single read port ram
// registered read; no dependencies
`timescale 1ns / 1ps

module dnle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 62,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/dns_name_label_encoder.sv
// dns_name_label_encoder: top level, label store control and output register
// depends on dnle_pkg and dnle_ram
`timescale 1ns / 1ps

// Usage:
//   s_* carries one name character per word (s_tdata); a dot ends a label and
//   a zero character ends the name. m_* carries the encoded bytes (m_tdata),
//   m_tlast marks the last byte caused by one input word, m_tuser flags the
//   name terminator and a label that was cut at LABEL_MAX characters.
//   Ordinary characters are taken one per cycle and written to the label
//   store (those past LABEL_MAX are dropped); they give no output. A dot or
//   zero is taken into the sequencer state, then the block stops taking words
//   while it sends from the output register the length byte and the stored
//   characters, one per cycle while the receiver accepts, read out of the
//   label store ram (one read port, address steered ahead so no bubbles), and
//   after a zero the name terminator; a zero ending an empty name sends only
//   the terminator.
//   When the receiver stalls the output register holds its byte and the
//   sequencer waits with it; words are taken again once the last byte of the
//   label or terminator sits in the output register.
//   Synchronous reset clears the sequencer, label count and flags; the label
//   store itself needs no clearing, only written entries are ever read.
module dns_name_label_encoder #(
  parameter int LABEL_MAX = dnle_pkg::LABEL_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [dnle_pkg::BYTE_W-1:0] s_tdata,  // [7:0] name_char
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [dnle_pkg::BYTE_W-1:0] m_tdata,  // [7:0] out_byte
  output logic                        m_tlast,
  output logic [dnle_pkg::USER_W-1:0] m_tuser   // [0] name_done, [1] label_too_long
);

  import dnle_pkg::*;

  localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
  localparam int CW = $clog2(LABEL_MAX + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(LABEL_MAX);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_CHR,
    ST_TERM
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic            ovf;
  logic            started;
  logic [CW-1:0]   flush_cnt;
  logic            flush_tl;
  logic            flush_zero;
  logic [AW-1:0]   idx;
  logic [AW-1:0]   idx_next;
  logic [CW-1:0]   idx_inc;
  logic            chr_last;
  logic            ofree;
  logic            emit;
  logic            in_acc;
  logic            is_null;
  logic            is_dot;
  logic            wr_en;
  logic [BYTE_W-1:0] rd_data;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign is_null  = (s_tdata == NULL_CHAR);
  assign is_dot   = (s_tdata == DOT_CHAR);
  assign wr_en    = in_acc && !is_null && !is_dot && (count < CNT_MAX);
  assign ofree    = !m_tvalid || m_tready;
  assign emit     = ofree && (state != ST_IDLE);
  assign idx_inc  = CW'(idx) + CW'(1);
  assign chr_last = (idx_inc == flush_cnt);

  always_comb begin
    idx_next = idx;
    if (ofree && (state == ST_LEN)) begin
      idx_next = '0;
    end else if (ofree && (state == ST_CHR)) begin
      idx_next = idx + AW'(1);
    end
  end

  dnle_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LABEL_MAX)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[AW-1:0]),
    .wdata (s_tdata),
    .raddr (idx_next),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      ovf      <= 1'b0;
      started  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (is_null || is_dot) begin
              flush_cnt  <= count;
              flush_tl   <= ovf;
              flush_zero <= is_null;
              count      <= '0;
              ovf        <= 1'b0;
              started    <= is_dot;
              if (is_null && !started && (count == '0)) begin
                state <= ST_TERM;
              end else begin
                state <= ST_LEN;
              end
            end else begin
              started <= 1'b1;
              if (count < CNT_MAX) begin
                count <= count + CW'(1);
              end else begin
                ovf <= 1'b1;
              end
            end
          end
        end
        ST_LEN: begin
          if (ofree) begin
            m_tdata    <= {{(BYTE_W-CW){1'b0}}, flush_cnt};
            m_tlast    <= (flush_cnt == '0) && !flush_zero;
            m_tuser[USER_DONE] <= 1'b0;
            m_tuser[USER_TL]   <= flush_tl;
            if (flush_cnt != '0) begin
              state <= ST_CHR;
            end else if (flush_zero) begin
              state <= ST_TERM;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_CHR: begin
          if (ofree) begin
            m_tdata    <= rd_data;
            m_tlast    <= chr_last && !flush_zero;
            m_tuser[USER_DONE] <= 1'b0;
            m_tuser[USER_TL]   <= flush_tl;
            if (chr_last) begin
              state <= flush_zero ? ST_TERM : ST_IDLE;
            end
          end
        end
        ST_TERM: begin
          if (ofree) begin
            m_tdata    <= NULL_CHAR;
            m_tlast    <= 1'b1;
            m_tuser[USER_DONE] <= 1'b1;
            m_tuser[USER_TL]   <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("label count beyond limit");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_IDLE))
    else $error("label store written while emitting");

  a_chr_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHR) |-> (CW'(idx) < flush_cnt))
    else $error("read index past held label");

  a_term_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[USER_DONE]) |-> (m_tlast && (m_tdata == NULL_CHAR)
      && !m_tuser[USER_TL]))
    else $error("malformed name terminator");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast && $past(emit)) |-> (state == ST_IDLE))
    else $error("last word loaded while sequencer still busy");
`endif

endmodule

// File: dv/tb_dns_name_label_encoder.sv
// tb_dns_name_label_encoder: self-checking bench for the dns name label encoder
// streams dotted names in, predicts the length/character/terminator bytes and compares
// depends on dnle_pkg and dns_name_label_encoder
`timescale 1ns / 1ps

module tb_dns_name_label_encoder;
  import dnle_pkg::*;

  localparam int LABEL_MAX  = LABEL_MAX_DEF;
  localparam int IDLE_LIMIT = 4000;
  localparam int MAX_SHOWN  = 50;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              done;
    logic              too_long;
  } enc_byte_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [BYTE_W-1:0] s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [BYTE_W-1:0] m_tdata;
  logic              m_tlast;
  logic [USER_W-1:0] m_tuser;

  dns_name_label_encoder #(.LABEL_MAX(LABEL_MAX)) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  // predictor state
  logic [BYTE_W-1:0] label_chars [LABEL_MAX];
  int                label_len;
  logic              label_cut;
  logic              name_open;

  logic [BYTE_W-1:0] name_chars [$];
  enc_byte_t         encoded_q [$];
  int                queued_words;
  int                taken_words;
  int                errors;
  int                idle_cycles;
  int                send_idle_pct;
  int                recv_stall_pct;
  logic              in_taken;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic flag_error(input string msg);
    if (errors < MAX_SHOWN) $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic flush_label(input logic mark_last);
    enc_byte_t b;
    b = '{data: BYTE_W'(label_len), last: mark_last && label_len == 0, done: 1'b0,
          too_long: label_cut};
    encoded_q.push_back(b);
    for (int i = 0; i < label_len; i++) begin
      b = '{data: label_chars[i], last: mark_last && i == label_len - 1, done: 1'b0,
            too_long: label_cut};
      encoded_q.push_back(b);
    end
    label_len = 0;
    label_cut = 1'b0;
  endtask

  task automatic encode_char(input logic [BYTE_W-1:0] c);
    if (c == NULL_CHAR) begin
      if (name_open || label_len != 0) flush_label(1'b0);
      encoded_q.push_back('{data: NULL_CHAR, last: 1'b1, done: 1'b1, too_long: 1'b0});
      label_len = 0;
      label_cut = 1'b0;
      name_open = 1'b0;
    end else begin
      name_open = 1'b1;
      if (c == DOT_CHAR) begin
        flush_label(1'b1);
      end else if (label_len < LABEL_MAX) begin
        label_chars[label_len] = c;
        label_len++;
      end else begin
        label_cut = 1'b1;
      end
    end
  endtask

  task automatic check_byte();
    enc_byte_t got;
    enc_byte_t want;
    got = '{data: m_tdata, last: m_tlast, done: m_tuser[USER_DONE],
            too_long: m_tuser[USER_TL]};
    if (encoded_q.size() == 0) begin
      flag_error($sformatf("unexpected word data %h last %b done %b tl %b",
                           got.data, got.last, got.done, got.too_long));
    end else begin
      want = encoded_q.pop_front();
      if (got !== want)
        flag_error($sformatf("got data %h last %b done %b tl %b, want %h %b %b %b",
                             got.data, got.last, got.done, got.too_long,
                             want.data, want.last, want.done, want.too_long));
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || in_taken) begin
        if (name_chars.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= name_chars.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      in_taken    <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        encode_char(s_tdata);
        taken_words++;
      end
      if (m_tvalid && m_tready) check_byte();
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic add_char(input logic [BYTE_W-1:0] c);
    name_chars.push_back(c);
    queued_words++;
  endtask

  function automatic logic [BYTE_W-1:0] pick_label_char();
    logic [BYTE_W-1:0] c;
    c = BYTE_W'($urandom_range(1, 255));
    if (c == DOT_CHAR) c = 8'h2D;
    return c;
  endfunction

  function automatic int pick_label_len();
    int r;
    r = $urandom_range(99);
    if (r < 82) return $urandom_range(0, 6);
    if (r < 98) return $urandom_range(7, 20);
    if (r < 99) return LABEL_MAX;
    return $urandom_range(LABEL_MAX + 1, LABEL_MAX + 3);
  endfunction

  task automatic add_label(input int len);
    for (int i = 0; i < len; i++) add_char(pick_label_char());
  endtask

  task automatic add_random_name();
    int nlabels;
    int n;
    int r;
    if ($urandom_range(9) == 0) begin
      // noise: raw bytes with dots and zeros anywhere
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(9);
        if (r == 0) add_char(DOT_CHAR);
        else if (r == 1) add_char(NULL_CHAR);
        else add_char(BYTE_W'($urandom_range(0, 255)));
      end
      if ($urandom_range(1)) add_char(NULL_CHAR);
    end else begin
      nlabels = $urandom_range(1, 4);
      if ($urandom_range(19) == 0) add_char(DOT_CHAR);
      for (int i = 0; i < nlabels; i++) begin
        add_label(pick_label_len());
        if (i < nlabels - 1) add_char(DOT_CHAR);
      end
      if ($urandom_range(9) == 0) add_char(DOT_CHAR);
      add_char(NULL_CHAR);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int upto);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (queued_words < upto) add_random_name();
    wait (taken_words == queued_words && encoded_q.size() == 0);
  endtask

  initial begin
    label_len      = 0;
    label_cut      = 1'b0;
    name_open      = 1'b0;
    queued_words   = 0;
    taken_words    = 0;
    errors         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty name
    add_char(NULL_CHAR);
    // lone dot: leading and trailing empty labels
    add_char(DOT_CHAR);
    add_char(NULL_CHAR);
    // doubled dots
    add_char("a");
    add_char(DOT_CHAR);
    add_char(DOT_CHAR);
    add_char("b");
    add_char(NULL_CHAR);
    // character extremes
    add_char(8'h01);
    add_char(8'hFF);
    add_char(8'h80);
    add_char(8'h7F);
    add_char(DOT_CHAR);
    add_char(NULL_CHAR);
    // trailing dot
    add_char("a");
    add_char("b");
    add_char(DOT_CHAR);
    add_char(NULL_CHAR);
    // single label
    add_char("x");
    add_char(NULL_CHAR);
    // label exactly at the limit
    add_label(LABEL_MAX);
    add_char(DOT_CHAR);
    add_char("b");
    add_char(NULL_CHAR);
    run_phase(0, 0, 140);

    run_phase(57, 0, 230);

    // label cut at the limit while the receiver stalls
    add_char("c");
    add_char(DOT_CHAR);
    add_label(LABEL_MAX + 2);
    add_char(NULL_CHAR);
    run_phase(0, 57, 350);

    run_phase(10, 10, 410);

    repeat (20) @(posedge clk);
    if (encoded_q.size() != 0) flag_error("bytes still expected at end of run");
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
